### rtl/core/srp_pkg.sv
// srp_pkg: shared types and constants for the s-record stream parser
// used by srp_front, srp_back, srp_result_queue and srecord_stream_parser
package srp_pkg;

  localparam int ADDR_W       = 32;
  localparam int FRONT_DEPTH  = 4;
  localparam int RESULT_DEPTH = 4;

  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_VERDICT = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  // one text character after classification
  typedef struct packed {
    logic       eos;
    logic       lf;
    logic       cr;
    logic       s_char;
    logic       hex;
    logic [3:0] nib;
  } char_class_t;

  typedef struct packed {
    logic [1:0]        result_kind;
    logic [ADDR_W-1:0] byte_address;
    logic [7:0]        data_byte;
    logic [3:0]        record_type;
    logic [2:0]        status;
    logic [ADDR_W-1:0] low_address;
    logic [ADDR_W-1:0] high_address;
    logic [ADDR_W-1:0] image_size;
    logic              no_data;
    logic              last_of_run;
  } result_t;

  // up to two results written per processed character
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } result_pair_t;

  // address field length in bytes per record type, zero for unchecked types
  function automatic logic [2:0] addr_bytes_for(input logic [3:0] rtype);
    logic [2:0] nbytes;
    unique case (rtype)
      4'd0, 4'd1, 4'd5, 4'd9: nbytes = 3'd2;
      4'd2, 4'd6, 4'd8:       nbytes = 3'd3;
      4'd3, 4'd7:             nbytes = 3'd4;
      default:                nbytes = 3'd0;
    endcase
    return nbytes;
  endfunction

endpackage

### rtl/core/srp_front.sv
// srp_front: accepts text characters, classifies them and holds them in a short queue
// depends on srp_pkg
module srp_front #(
  parameter int DEPTH = srp_pkg::FRONT_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          text_byte,
  input  logic                end_of_stream,
  input  logic                push,
  output logic                full,
  output logic                item_valid,
  output srp_pkg::char_class_t item,
  input  logic                item_pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UF = 8'h46;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;
  localparam logic [7:0] CH_US = 8'h53;
  localparam logic [7:0] CH_LS = 8'h73;

  srp_pkg::char_class_t cls;
  srp_pkg::char_class_t slots [DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [CNT_W-1:0]     count;
  logic                 push_ok;
  logic                 pop_ok;

  always_comb begin
    cls        = '0;
    cls.eos    = end_of_stream;
    cls.lf     = (text_byte == CH_LF);
    cls.cr     = (text_byte == CH_CR);
    cls.s_char = (text_byte == CH_US) || (text_byte == CH_LS);
    if (text_byte >= CH_0 && text_byte <= CH_9) begin
      cls.hex = 1'b1;
      cls.nib = 4'(text_byte - CH_0);
    end else if (text_byte >= CH_UA && text_byte <= CH_UF) begin
      cls.hex = 1'b1;
      cls.nib = 4'(text_byte - (CH_UA - 8'd10));
    end else if (text_byte >= CH_LA && text_byte <= CH_LF_HEX) begin
      cls.hex = 1'b1;
      cls.nib = 4'(text_byte - (CH_LA - 8'd10));
    end
  end

  assign full       = (count == CNT_W'(DEPTH));
  assign item_valid = (count != '0);
  assign item       = slots[rd_ptr];
  assign push_ok    = push && !full;
  assign pop_ok     = item_pop && item_valid;

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slots[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push_ok) - CNT_W'(pop_ok);
    end
  end

endmodule

### rtl/core/srp_back.sv
// srp_back: record parser, takes classified characters and produces data, verdict
// and summary results; depends on srp_pkg
module srp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  srp_pkg::char_class_t item,
  output logic                 item_pop,
  input  logic                 res_room,
  output srp_pkg::result_pair_t res
);

  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_TYPE  = 3'd1;
  localparam logic [2:0] PH_COUNT = 3'd2;
  localparam logic [2:0] PH_BODY  = 3'd3;
  localparam logic [2:0] PH_SKIP  = 3'd4;
  localparam logic [2:0] PH_DEAD  = 3'd5;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_SHORT = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_HEX   = 3'd3;
  localparam logic [2:0] ST_LEN   = 3'd4;
  localparam logic [2:0] ST_SUM   = 3'd5;

  localparam logic [7:0] SUM_GOOD = 8'hFF;
  localparam logic [srp_pkg::ADDR_W-1:0] LOW_RESET = '1;

  localparam int AW = srp_pkg::ADDR_W;

  logic          take;
  logic [2:0]    phase, phase_next;
  logic [3:0]    cur_type, cur_type_next;
  logic [7:0]    byte_count, byte_count_next;
  logic [8:0]    digits, digits_next;
  logic [2:0]    addr_left, addr_left_next;
  logic [AW-1:0] addr_acc, addr_acc_next;
  logic [AW-1:0] next_addr, next_addr_next;
  logic [AW-1:0] last_addr, last_addr_next;
  logic          have_data, have_data_next;
  logic [3:0]    high_nib, high_nib_next;
  logic          nib_pend, nib_pend_next;
  logic [7:0]    run_sum, run_sum_next;
  logic          cr_seen, cr_seen_next;
  logic [AW-1:0] low_addr, low_addr_next;
  logic [AW-1:0] high_addr, high_addr_next;
  logic          any_data, any_data_next;
  logic [2:0]    err, err_next;

  logic             do_verdict;
  logic             do_close;
  logic             emit_data;
  logic [2:0]       v_status;
  logic [2:0]       ab;
  logic [7:0]       byte_val;
  logic [8:0]       dig_total;
  logic [8:0]       digits_inc;
  logic [AW-1:0]    acc_shift;
  srp_pkg::result_t data_res;
  srp_pkg::result_t verdict_res;
  srp_pkg::result_t summ_res;

  assign take      = item_valid && res_room;
  assign item_pop  = take;
  assign dig_total = {byte_count, 1'b0};
  assign digits_inc = digits + 9'd1;
  assign ab        = srp_pkg::addr_bytes_for(cur_type);
  assign byte_val  = {high_nib, item.nib};
  assign acc_shift = {addr_acc[AW-9:0], byte_val};

  always_comb begin
    phase_next      = phase;
    cur_type_next   = cur_type;
    byte_count_next = byte_count;
    digits_next     = digits;
    addr_left_next  = addr_left;
    addr_acc_next   = addr_acc;
    next_addr_next  = next_addr;
    last_addr_next  = last_addr;
    have_data_next  = have_data;
    high_nib_next   = high_nib;
    nib_pend_next   = nib_pend;
    run_sum_next    = run_sum;
    cr_seen_next    = cr_seen;
    low_addr_next   = low_addr;
    high_addr_next  = high_addr;
    any_data_next   = any_data;
    err_next        = err;
    do_verdict      = 1'b0;
    do_close        = 1'b0;
    emit_data       = 1'b0;
    v_status        = ST_OK;

    if (take) begin
      if (item.eos) begin
        unique case (phase)
          PH_START: begin
            if (cr_seen) begin
              do_verdict = 1'b1;
              v_status   = ST_SHORT;
            end
          end
          PH_TYPE, PH_COUNT: begin
            do_verdict = 1'b1;
            v_status   = ST_SHORT;
          end
          PH_BODY: do_close = 1'b1;
          PH_SKIP: do_verdict = 1'b1;
          default: ;
        endcase
      end else begin
        unique case (phase)
          PH_START, PH_TYPE, PH_COUNT: begin
            priority if (item.lf) begin
              do_verdict = 1'b1;
              v_status   = ST_SHORT;
            end else if (cr_seen) begin
              do_verdict = 1'b1;
              v_status   = (phase == PH_START) ? ST_START : ST_HEX;
            end else if (item.cr) begin
              cr_seen_next = 1'b1;
            end else if (phase == PH_START) begin
              if (item.s_char) begin
                phase_next = PH_TYPE;
              end else begin
                do_verdict = 1'b1;
                v_status   = ST_START;
              end
            end else if (!item.hex) begin
              do_verdict = 1'b1;
              v_status   = ST_HEX;
            end else if (phase == PH_TYPE) begin
              cur_type_next = item.nib;
              phase_next    = PH_COUNT;
            end else if (!nib_pend) begin
              high_nib_next = item.nib;
              nib_pend_next = 1'b1;
            end else begin
              nib_pend_next   = 1'b0;
              byte_count_next = byte_val;
              if (ab == 3'd0) begin
                phase_next = PH_SKIP;
              end else if (byte_val <= {5'b0, ab}) begin
                // count must cover the address and the checksum
                do_verdict = 1'b1;
                v_status   = ST_LEN;
              end else begin
                addr_left_next = ab;
                run_sum_next   = byte_val;
                digits_next    = '0;
                phase_next     = PH_BODY;
              end
            end
          end
          PH_BODY: begin
            priority if (item.lf) begin
              do_close = 1'b1;
            end else if (cr_seen) begin
              do_verdict = 1'b1;
              v_status   = ST_LEN;
            end else if (item.cr) begin
              cr_seen_next = 1'b1;
            end else if (!item.hex) begin
              do_verdict = 1'b1;
              v_status   = ST_HEX;
            end else if (digits >= dig_total) begin
              do_verdict = 1'b1;
              v_status   = ST_LEN;
            end else begin
              digits_next = digits_inc;
              if (!nib_pend) begin
                high_nib_next = item.nib;
                nib_pend_next = 1'b1;
              end else begin
                nib_pend_next = 1'b0;
                run_sum_next  = run_sum + byte_val;
                if (addr_left != 3'd0) begin
                  addr_acc_next  = acc_shift;
                  addr_left_next = addr_left - 3'd1;
                  if (addr_left == 3'd1) begin
                    next_addr_next = acc_shift;
                  end
                end else if (digits_inc < dig_total) begin
                  // data byte, the checksum byte is the one at the very end
                  next_addr_next = next_addr + 1'b1;
                  last_addr_next = next_addr;
                  have_data_next = 1'b1;
                  emit_data      = (cur_type >= 4'd1) && (cur_type <= 4'd3);
                end
              end
            end
          end
          PH_SKIP: begin
            if (item.lf) begin
              do_verdict = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end

    if (do_close) begin
      do_verdict = 1'b1;
      if (digits != dig_total) begin
        v_status = ST_LEN;
      end else if (run_sum != SUM_GOOD) begin
        v_status = ST_SUM;
      end else begin
        v_status = ST_OK;
      end
      if (v_status == ST_OK && cur_type >= 4'd1 && cur_type <= 4'd3 && have_data) begin
        if (addr_acc < low_addr) begin
          low_addr_next = addr_acc;
        end
        if (last_addr > high_addr) begin
          high_addr_next = last_addr;
        end
        any_data_next = 1'b1;
      end
    end

    if (do_verdict) begin
      if (v_status != ST_OK) begin
        if (err == ST_OK) begin
          err_next = v_status;
        end
        phase_next = PH_DEAD;
      end else begin
        phase_next      = PH_START;
        cur_type_next   = '0;
        byte_count_next = '0;
        digits_next     = '0;
        addr_left_next  = '0;
        addr_acc_next   = '0;
        next_addr_next  = '0;
        last_addr_next  = '0;
        have_data_next  = 1'b0;
        high_nib_next   = '0;
        nib_pend_next   = 1'b0;
        run_sum_next    = '0;
        cr_seen_next    = 1'b0;
      end
    end

    // summary sees the range and error after the closing verdict
    summ_res             = '0;
    summ_res.result_kind = srp_pkg::KIND_SUMMARY;
    summ_res.status      = err_next;
    summ_res.last_of_run = 1'b1;
    if (any_data_next) begin
      summ_res.low_address  = low_addr_next;
      summ_res.high_address = high_addr_next;
      summ_res.image_size   = high_addr_next - low_addr_next + 1'b1;
    end else begin
      summ_res.no_data = 1'b1;
    end

    if (take && item.eos) begin
      phase_next      = PH_START;
      cur_type_next   = '0;
      byte_count_next = '0;
      digits_next     = '0;
      addr_left_next  = '0;
      addr_acc_next   = '0;
      next_addr_next  = '0;
      last_addr_next  = '0;
      have_data_next  = 1'b0;
      high_nib_next   = '0;
      nib_pend_next   = 1'b0;
      run_sum_next    = '0;
      cr_seen_next    = 1'b0;
      low_addr_next   = LOW_RESET;
      high_addr_next  = '0;
      any_data_next   = 1'b0;
      err_next        = ST_OK;
    end

    data_res              = '0;
    data_res.result_kind  = srp_pkg::KIND_DATA;
    data_res.byte_address = next_addr;
    data_res.data_byte    = byte_val;
    data_res.record_type  = cur_type;
    data_res.status       = ST_OK;
    data_res.last_of_run  = 1'b1;

    verdict_res              = '0;
    verdict_res.result_kind  = srp_pkg::KIND_VERDICT;
    verdict_res.byte_address = addr_acc;
    verdict_res.record_type  = cur_type;
    verdict_res.status       = v_status;
    verdict_res.last_of_run  = !item.eos;

    res = '0;
    if (emit_data) begin
      res.count = 2'd1;
      res.first = data_res;
    end else if (do_verdict) begin
      res.first  = verdict_res;
      res.second = summ_res;
      res.count  = item.eos ? 2'd2 : 2'd1;
    end else if (take && item.eos) begin
      res.count = 2'd1;
      res.first = summ_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_START;
      cur_type   <= '0;
      byte_count <= '0;
      digits     <= '0;
      addr_left  <= '0;
      addr_acc   <= '0;
      next_addr  <= '0;
      last_addr  <= '0;
      have_data  <= 1'b0;
      high_nib   <= '0;
      nib_pend   <= 1'b0;
      run_sum    <= '0;
      cr_seen    <= 1'b0;
      low_addr   <= LOW_RESET;
      high_addr  <= '0;
      any_data   <= 1'b0;
      err        <= ST_OK;
    end else if (take) begin
      phase      <= phase_next;
      cur_type   <= cur_type_next;
      byte_count <= byte_count_next;
      digits     <= digits_next;
      addr_left  <= addr_left_next;
      addr_acc   <= addr_acc_next;
      next_addr  <= next_addr_next;
      last_addr  <= last_addr_next;
      have_data  <= have_data_next;
      high_nib   <= high_nib_next;
      nib_pend   <= nib_pend_next;
      run_sum    <= run_sum_next;
      cr_seen    <= cr_seen_next;
      low_addr   <= low_addr_next;
      high_addr  <= high_addr_next;
      any_data   <= any_data_next;
      err        <= err_next;
    end
  end

`ifndef SYNTHESIS
  a_pair_only_at_end: assert property (@(posedge clk) disable iff (rst)
    take && res.count == 2'd2 |-> item.eos)
    else $error("two results from a text character");

  a_end_ends_in_summary: assert property (@(posedge clk) disable iff (rst)
    take && item.eos |-> (res.count == 2'd1 && res.first.result_kind == srp_pkg::KIND_SUMMARY)
      || (res.count == 2'd2 && res.second.result_kind == srp_pkg::KIND_SUMMARY))
    else $error("end of stream without summary last");

  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    take && item.eos |=> phase == PH_START && err == ST_OK && !any_data)
    else $error("state not restarted after summary");

  a_dead_has_error: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DEAD |-> err != ST_OK)
    else $error("parser stopped without a recorded error");
`endif

endmodule

### rtl/core/srp_result_queue.sv
// srp_result_queue: result queue taking up to two results per cycle, one out per pop
// depends on srp_pkg
module srp_result_queue #(
  parameter int DEPTH = srp_pkg::RESULT_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  srp_pkg::result_pair_t wr,
  output logic                  room,
  output srp_pkg::result_t      head,
  output logic                  empty,
  input  logic                  pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  srp_pkg::result_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] wr_ptr_1;
  logic [PTR_W-1:0] wr_ptr_2;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop_ok;

  assign wr_ptr_1 = (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
  assign wr_ptr_2 = (wr_ptr_1 == PTR_LAST) ? '0 : wr_ptr_1 + 1'b1;

  // room for a worst-case pair
  assign room   = (count <= CNT_W'(DEPTH - 2));
  assign empty  = (count == '0);
  assign head   = slots[rd_ptr];
  assign pop_ok = pop && !empty;

  always_ff @(posedge clk) begin
    if (wr.count != 2'd0) begin
      slots[wr_ptr] <= wr.first;
    end
    if (wr.count == 2'd2) begin
      slots[wr_ptr_1] <= wr.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      unique case (wr.count)
        2'd1:    wr_ptr <= wr_ptr_1;
        2'd2:    wr_ptr <= wr_ptr_2;
        default: wr_ptr <= wr_ptr;
      endcase
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(wr.count) - CNT_W'(pop_ok);
    end
  end

endmodule

### rtl/core/srecord_stream_parser.sv
// path: each character is registered in the front queue, and its results in the result queue before they can be popped
// throughput: one character per cycle while the result queue has room; an end item gives up to two results
// the parser runs one character per cycle whenever the result queue has room for two
// reset: synchronous rst empties both queues and returns the parser to start of line
// with an empty address range and no error; no clearing pass is needed
module srecord_stream_parser #(
  parameter int FRONT_DEPTH  = srp_pkg::FRONT_DEPTH,
  parameter int RESULT_DEPTH = srp_pkg::RESULT_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [7:0]                 text_byte,
  input  logic                       end_of_stream,
  input  logic                       push,
  output logic                       full,
  output logic [1:0]                 result_kind,
  output logic [srp_pkg::ADDR_W-1:0] byte_address,
  output logic [7:0]                 data_byte,
  output logic [3:0]                 record_type,
  output logic [2:0]                 status,
  output logic [srp_pkg::ADDR_W-1:0] low_address,
  output logic [srp_pkg::ADDR_W-1:0] high_address,
  output logic [srp_pkg::ADDR_W-1:0] image_size,
  output logic                       no_data,
  output logic                       last_of_run,
  output logic                       empty,
  input  logic                       pop
);

  logic                  item_valid;
  logic                  item_pop;
  srp_pkg::char_class_t  item;
  logic                  res_room;
  srp_pkg::result_pair_t res;
  srp_pkg::result_t      head;

  srp_front #(
    .DEPTH (FRONT_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .text_byte     (text_byte),
    .end_of_stream (end_of_stream),
    .push          (push),
    .full          (full),
    .item_valid    (item_valid),
    .item          (item),
    .item_pop      (item_pop)
  );

  srp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .res_room   (res_room),
    .res        (res)
  );

  srp_result_queue #(
    .DEPTH (RESULT_DEPTH)
  ) u_result_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (res),
    .room  (res_room),
    .head  (head),
    .empty (empty),
    .pop   (pop)
  );

  assign result_kind  = head.result_kind;
  assign byte_address = head.byte_address;
  assign data_byte    = head.data_byte;
  assign record_type  = head.record_type;
  assign status       = head.status;
  assign low_address  = head.low_address;
  assign high_address = head.high_address;
  assign image_size   = head.image_size;
  assign no_data      = head.no_data;
  assign last_of_run  = head.last_of_run;

endmodule
